### hw/rtl/qssd_pkg.sv
package qssd_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_VALUE = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  // Escape tracking
  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] HEX_ALPHA  = 8'd10;

  localparam int MAX_RES  = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW  = 2;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [1:0]              cnt;
    logic                    last;
    result_t [MAX_RES-1:0]   res;
  } bundle_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
        t = c - CH_0;
      end else if (c >= CH_UA && c <= CH_UF) begin
        t = c - CH_UA + HEX_ALPHA;
      end else if (c >= CH_LA && c <= CH_LF) begin
        t = c - CH_LA + HEX_ALPHA;
      end
      return t[3:0];
    end
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

### hw/rtl/qssd_in_if.sv
interface qssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_byte;
  logic       is_last;

  modport source (output valid, output query_byte, output is_last, input ready);
  modport sink (input valid, input query_byte, input is_last, output ready);
endinterface

### hw/rtl/qssd_out_if.sv
interface qssd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] decoded_byte;
  logic       run_last;
  logic       query_end;

  modport source (output valid, output kind, output decoded_byte, output run_last,
                  output query_end, input ready);
  modport sink (input valid, input kind, input decoded_byte, input run_last,
                input query_end, output ready);
endinterface

### hw/rtl/qssd_front.sv
module qssd_front (
  input  logic              clk,
  input  logic              rst_n,
  qssd_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              q_push,
  output qssd_pkg::bundle_t q_data
);

  qssd_pkg::phase_t ph_r, ph_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             key_r, key_nxt;
  logic             accept;
  logic [1:0]       n;
  logic             delim;
  logic [7:0]       c;
  qssd_pkg::bundle_t b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.query_byte;
  assign delim       = (c == qssd_pkg::CH_EQ) || (c == qssd_pkg::CH_AMP) ||
                       (c == qssd_pkg::CH_SEMI) || (c == qssd_pkg::CH_HASH);

  // Classify the byte and build its result bundle
  always_comb begin
    b        = '0;
    n        = 2'd0;
    ph_nxt   = ph_r;
    held_nxt = held_r;
    key_nxt  = key_r;
    if (delim) begin
      // flush a cut-short escape, then the segment event
      if (ph_r != qssd_pkg::PH_NONE) begin
        b.res[n] = '{kind: qssd_pkg::KIND_BYTE, data: qssd_pkg::CH_PCT};
        n = n + 2'd1;
        if (ph_r == qssd_pkg::PH_DIGIT) begin
          b.res[n] = '{kind: qssd_pkg::KIND_BYTE, data: qssd_pkg::plain_byte(held_r)};
          n = n + 2'd1;
        end
      end
      ph_nxt   = qssd_pkg::PH_NONE;
      held_nxt = 8'd0;
      if (c == qssd_pkg::CH_EQ) begin
        b.res[n] = '{kind: qssd_pkg::KIND_KEY, data: 8'd0};
        n = n + 2'd1;
        key_nxt = 1'b1;
      end else begin
        b.res[n] = '{kind: key_r ? qssd_pkg::KIND_VALUE : qssd_pkg::KIND_EMPTY, data: 8'd0};
        n = n + 2'd1;
        key_nxt = 1'b0;
      end
    end else begin
      unique case (ph_r)
        qssd_pkg::PH_PCT: begin
          held_nxt = c;
          ph_nxt   = qssd_pkg::PH_DIGIT;
        end
        qssd_pkg::PH_DIGIT: begin
          b.res[n] = '{kind: qssd_pkg::KIND_BYTE,
                       data: {qssd_pkg::hex_value(held_r), qssd_pkg::hex_value(c)}};
          n = n + 2'd1;
          ph_nxt   = qssd_pkg::PH_NONE;
          held_nxt = 8'd0;
        end
        qssd_pkg::PH_NONE: begin
          if (c == qssd_pkg::CH_PCT) begin
            ph_nxt = qssd_pkg::PH_PCT;
          end else begin
            b.res[n] = '{kind: qssd_pkg::KIND_BYTE, data: qssd_pkg::plain_byte(c)};
            n = n + 2'd1;
          end
        end
        default: begin
          ph_nxt   = qssd_pkg::PH_NONE;
          held_nxt = 8'd0;
        end
      endcase
      // end of query: flush what is pending, then close the segment
      if (in_ch.is_last) begin
        if (ph_nxt != qssd_pkg::PH_NONE) begin
          b.res[n] = '{kind: qssd_pkg::KIND_BYTE, data: qssd_pkg::CH_PCT};
          n = n + 2'd1;
          if (ph_nxt == qssd_pkg::PH_DIGIT) begin
            b.res[n] = '{kind: qssd_pkg::KIND_BYTE,
                         data: qssd_pkg::plain_byte(held_nxt)};
            n = n + 2'd1;
          end
        end
        b.res[n] = '{kind: key_r ? qssd_pkg::KIND_VALUE : qssd_pkg::KIND_EMPTY,
                     data: 8'd0};
        n = n + 2'd1;
      end
    end
    // end of query returns everything to reset
    if (in_ch.is_last) begin
      ph_nxt   = qssd_pkg::PH_NONE;
      held_nxt = 8'd0;
      key_nxt  = 1'b0;
    end
    b.cnt  = n;
    b.last = in_ch.is_last;
  end

  assign q_push = accept && (n != 2'd0);
  assign q_data = b;

  // Advance segment state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= qssd_pkg::PH_NONE;
      held_r <= 8'd0;
      key_r  <= 1'b0;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      held_r <= held_nxt;
      key_r  <= key_nxt;
    end
  end

endmodule

### hw/rtl/qssd_fifo.sv
module qssd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qssd_pkg::bundle_t wr_data,
  input  logic              pop,
  output qssd_pkg::bundle_t rd_data,
  output logic              full,
  output logic              empty
);

  qssd_pkg::bundle_t             mem_r [qssd_pkg::FIFO_DEPTH];
  logic [qssd_pkg::FIFO_AW:0]    wr_ptr_r, rd_ptr_r;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[qssd_pkg::FIFO_AW-1:0] == rd_ptr_r[qssd_pkg::FIFO_AW-1:0]) &&
                   (wr_ptr_r[qssd_pkg::FIFO_AW] != rd_ptr_r[qssd_pkg::FIFO_AW]);
  assign rd_data = mem_r[rd_ptr_r[qssd_pkg::FIFO_AW-1:0]];

  // Store entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r[qssd_pkg::FIFO_AW-1:0]] <= wr_data;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("queue pop while empty");
  a_nonzero_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (wr_data.cnt != 2'd0))
    else $error("empty bundle pushed");
  a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
    ((wr_ptr_r - rd_ptr_r) <= 3'(qssd_pkg::FIFO_DEPTH)))
    else $error("queue occupancy out of range");
`endif

endmodule

### hw/rtl/qssd_back.sv
module qssd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  qssd_pkg::bundle_t q_data,
  input  logic              q_empty,
  output logic              q_pop,
  qssd_out_if.source        out_ch
);

  logic [1:0]       idx_r;
  logic             load;
  logic             at_end;
  qssd_pkg::result_t cur;
  logic             valid_r;
  logic [1:0]       kind_r;
  logic [7:0]       data_r;
  logic             run_last_r;
  logic             query_end_r;

  assign load   = !q_empty && (!valid_r || out_ch.ready);
  assign cur    = q_data.res[idx_r];
  assign at_end = (idx_r == q_data.cnt - 2'd1);
  assign q_pop  = load && at_end;

  // Step through the head bundle one result per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r      <= cur.kind;
      data_r      <= cur.data;
      run_last_r  <= at_end;
      query_end_r <= at_end && q_data.last;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.decoded_byte = data_r;
  assign out_ch.run_last     = run_last_r;
  assign out_ch.query_end    = query_end_r;

endmodule

### hw/rtl/query_string_splitter_decoder_unit.sv
// A byte's results are written to the bundle queue, then loaded into the output register.
// Throughput: one input byte per cycle while the result queue has room; results
// drain one per cycle while out_ch.ready is high.
// The 4-entry bundle queue between classifier and serializer absorbs bursts.
// Reset: synchronous, active-low rst_n clears escape and key state and empties the queue.
module query_string_splitter_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  qssd_in_if.sink    in_ch,
  qssd_out_if.source out_ch
);

  logic              q_push, q_pop, q_full, q_empty;
  qssd_pkg::bundle_t q_wr, q_rd;

  qssd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr)
  );

  qssd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  qssd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_rd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
